// File: sv/sll_pkg.sv
// Shared constants and codes for the sorted list engine.
`default_nettype none

package sll_pkg;

	localparam int CAPACITY_DEF  = 64;
	localparam int KEY_WIDTH_DEF = 16;

	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 6;
	localparam int COUNT_W  = 7;
	localparam int TOTAL_W  = 32;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// Add a small amount to a running total, pinning it at all ones.
	function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] total,
	                                               input logic [TOTAL_W-1:0] amount);
		logic [TOTAL_W:0] sum;
		sum = {1'b0, total} + {1'b0, amount};
		if (sum[TOTAL_W]) begin
			return {TOTAL_W{1'b1}};
		end
		return sum[TOTAL_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: sv/sorted_list_linear_insert.sv
// Sorted list engine: ascending key store with linear search and shift.
//
// Holds up to CAPACITY signed keys in ascending order in a single-port-read,
// single-port-write memory with registered read data. One request is worked at
// a time; in_stall stays high from acceptance until the result is loaded into
// the output register. Insert scans from the bottom for the first entry greater
// than the key, shifts the entries from there up by one and writes the key in
// the gap, or appends it when no entry is greater; remove scans for an equal
// key and shifts the entries above it down by one. Clear, insert into a full
// list, remove from an empty list and the unused opcode skip the scan. While
// a result is held in the output register, the next result waits. Each step
// of the scan and of the shift is one memory read followed by one compare or
// one write. Compare and move totals saturate at 2^32-1.
// No clearing pass is needed after reset.
`default_nettype none

module sorted_list_linear_insert
	import sll_pkg::*;
#(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,

	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [OP_W-1:0]             opcode,
	input  wire logic signed [KEY_WIDTH-1:0] key,

	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [STATUS_W-1:0]              status,
	output logic [POS_W-1:0]                 position,
	output logic [COUNT_W-1:0]               entry_count,
	output logic [TOTAL_W-1:0]               compare_total,
	output logic [TOTAL_W-1:0]               move_total
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C = CW'(1);
	localparam logic [CW-1:0] TWO_C = CW'(2);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_SRD  = 8'b0000_0010,
		S_SCMP = 8'b0000_0100,
		S_MRD  = 8'b0000_1000,
		S_MWR  = 8'b0001_0000,
		S_PUT  = 8'b0010_0000,
		S_FIN  = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	state_t                  state_q;
	opcode_t                 op_q;
	logic signed [KEY_WIDTH-1:0] key_q;
	status_t                 status_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           idx_q;
	logic [CW-1:0]           pos_q;
	logic [CW-1:0]           cmp_q;
	logic [TOTAL_W-1:0]      cmp_total_q;
	logic [TOTAL_W-1:0]      move_total_q;

	logic signed [KEY_WIDTH-1:0] mem [CAPACITY];
	logic signed [KEY_WIDTH-1:0] rd_q;
	logic [AW-1:0]           rd_addr;
	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic signed [KEY_WIDTH-1:0] wr_data;

	logic                    accept;
	logic                    hit;
	logic                    last_scan;
	logic [CW-1:0]           idx_dec;
	logic [CW-1:0]           idx_inc;
	logic [CW-1:0]           moves;
	logic                    out_free;

	assign accept   = (state_q == S_IDLE) && in_valid;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid || !out_stall;

	assign idx_dec   = idx_q - ONE_C;
	assign idx_inc   = idx_q + ONE_C;
	assign last_scan = (idx_inc == count_q);
	assign hit       = (op_q == OP_INSERT) ? (rd_q > key_q) : (rd_q == key_q);
	assign moves     = (op_q == OP_INSERT) ? (count_q - pos_q) : (count_q - ONE_C - pos_q);

	// Memory port selection.
	always_comb begin
		rd_addr = idx_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_data = rd_q;
		case (state_q)
			S_MRD: begin
				rd_addr = (op_q == OP_INSERT) ? idx_dec[AW-1:0] : idx_inc[AW-1:0];
			end
			S_MWR: begin
				wr_en = 1'b1;
			end
			S_PUT: begin
				wr_en   = 1'b1;
				wr_addr = pos_q[AW-1:0];
				wr_data = key_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			op_q          <= OP_NONE;
			key_q         <= '0;
			status_q      <= ST_OK;
			count_q       <= '0;
			idx_q         <= '0;
			pos_q         <= '0;
			cmp_q         <= '0;
			cmp_total_q   <= '0;
			move_total_q  <= '0;
			out_valid     <= 1'b0;
			status        <= '0;
			position      <= '0;
			entry_count   <= '0;
			compare_total <= '0;
			move_total    <= '0;
		end else begin
			if (out_valid && !out_stall && state_q != S_DONE) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= opcode_t'(opcode);
						key_q    <= key;
						idx_q    <= '0;
						pos_q    <= '0;
						cmp_q    <= '0;
						case (opcode_t'(opcode))
							OP_INSERT: begin
								if (count_q == CAP_C) begin
									status_q <= ST_FULL;
									state_q  <= S_DONE;
								end else if (count_q == '0) begin
									status_q <= ST_OK;
									state_q  <= S_PUT;
								end else begin
									status_q <= ST_OK;
									state_q  <= S_SRD;
								end
							end
							OP_REMOVE: begin
								if (count_q == '0) begin
									status_q <= ST_EMPTY;
									state_q  <= S_DONE;
								end else begin
									status_q <= ST_OK;
									state_q  <= S_SRD;
								end
							end
							OP_CLEAR: begin
								status_q     <= ST_OK;
								count_q      <= '0;
								cmp_total_q  <= '0;
								move_total_q <= '0;
								state_q      <= S_DONE;
							end
							default: begin
								status_q <= ST_OK;
								state_q  <= S_DONE;
							end
						endcase
					end
				end
				S_SRD: begin
					state_q <= S_SCMP;
				end
				S_SCMP: begin
					cmp_q <= cmp_q + ONE_C;
					if (hit) begin
						pos_q <= idx_q;
						if (op_q == OP_INSERT) begin
							// shift up from the top end
							idx_q   <= count_q;
							state_q <= S_MRD;
						end else if (last_scan) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_MRD;
						end
					end else if (last_scan) begin
						if (op_q == OP_INSERT) begin
							pos_q   <= count_q;
							state_q <= S_PUT;
						end else begin
							status_q <= ST_NOT_FOUND;
							state_q  <= S_FIN;
						end
					end else begin
						idx_q   <= idx_inc;
						state_q <= S_SRD;
					end
				end
				S_MRD: begin
					state_q <= S_MWR;
				end
				S_MWR: begin
					if (op_q == OP_INSERT) begin
						idx_q   <= idx_dec;
						state_q <= (idx_dec == pos_q) ? S_PUT : S_MRD;
					end else begin
						idx_q   <= idx_inc;
						state_q <= (idx_q + TWO_C == count_q) ? S_FIN : S_MRD;
					end
				end
				S_PUT: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					cmp_total_q <= sat_add(cmp_total_q, TOTAL_W'(cmp_q));
					if (status_q == ST_OK) begin
						move_total_q <= sat_add(move_total_q, TOTAL_W'(moves));
						count_q      <= (op_q == OP_INSERT) ? count_q + ONE_C : count_q - ONE_C;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (out_free) begin
						out_valid     <= 1'b1;
						status        <= status_q;
						position      <= (status_q == ST_OK) ? POS_W'(pos_q) : '0;
						entry_count   <= COUNT_W'(count_q);
						compare_total <= cmp_total_q;
						move_total    <= move_total_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
